/* rtl/rgbfade_pkg.sv */
// shared constants and helper functions for the rgb led fade-cycle controller
package rgbfade_pkg;

    // intensity bounds
    localparam logic [7:0]  LVL_MAX = 8'd254;
    localparam logic [7:0]  LVL_MIN = 8'd10;

    // fade rate bounds in hundredths
    localparam logic [11:0] RATE_MIN = 12'd100;
    localparam logic [11:0] RATE_MAX = 12'd3200;

    // fade bound checks, in hundredths
    localparam logic [15:0] SRC_FLOOR_HUND = 16'd1000;
    localparam logic [15:0] DST_CEIL_HUND  = 16'd25500;
    localparam logic [15:0] HUND           = 16'd100;

    // reciprocals: x/100 = ((x>>2)*1311)>>15 for x < 4096,
    // x/1000 = ((x>>3)*2147484)>>28 for x < 2^24
    localparam logic [10:0] RECIP_25  = 11'd1311;
    localparam logic [21:0] RECIP_125 = 22'd2147484;

    // register reset values
    localparam logic [15:0] PERIOD_LOAD_RST = 16'd11362;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd170;
    localparam logic [6:0]  RATE_STEP_RST   = 7'd1;

    // register indexes (word address)
    localparam logic [1:0] REG_PERIOD_LOAD = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
    localparam logic [1:0] REG_RATE_STEP   = 2'd2;

    // manual target codes
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_CH0    = 3'd1;
    localparam logic [2:0] TGT_CH1    = 3'd2;
    localparam logic [2:0] TGT_CH2    = 3'd3;
    localparam logic [2:0] TGT_SELECT = 3'd4;

    // fade phases
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    // short press count limit
    localparam logic [1:0] SHORT_MAX = 2'd3;

    // rate divided by 100, truncated
    function automatic logic [5:0] div100(input logic [11:0] r);
        logic [20:0] p;
        p = 21'(r[11:2]) * 21'(RECIP_25);
        return p[20:15];
    endfunction

    // product divided by 1000, truncated
    function automatic logic [14:0] div1000(input logic [23:0] x);
        logic [42:0] p;
        p = 43'(x[23:3]) * 43'(RECIP_125);
        return p[42:28];
    endfunction

    // manual step of one channel, saturating at the bounds
    function automatic logic [7:0] adj_level(input logic [7:0] lvl, input logic up,
                                             input logic dn);
        logic [7:0] v;
        v = lvl;
        if (up) begin
            v = (v >= LVL_MAX) ? LVL_MAX : v + 8'd1;
        end
        if (dn) begin
            v = (v <= LVL_MIN) ? LVL_MIN : v - 8'd1;
        end
        return v;
    endfunction

    // saturating tick counter
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

/* rtl/rgb_led_fade_cycle_controller_top.sv */
// top level of the rgb led fade-cycle controller: state update, pwm scaling, apb registers
//
// Each input transaction is one button sampling tick (s_tdata bit 0 up, bit 1 down, both
// active high) and yields exactly one result transaction with three pwm compare values and
// the mode, target, phase and rate status. One tick is accepted every clock cycle unless
// back-pressure on m_tready stalls the pipeline, one stage at a time: the whole state update
// for a tick (rate clamp, fade step, press counting, manual step) is done in the cycle it is
// accepted, and the scaling intensity * period_load / 1000 follows in two pipeline stages
// (one multiply register, one reciprocal-multiply into the output register). Registers are
// written over apb at byte addresses 0 (period_load), 4 (long_press_ticks) and 8
// (rate_step). The user must write them only while no tick is in flight; it is unchecked.
module rgb_led_fade_cycle_controller_top
    import rgbfade_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] up_pressed, [1] down_pressed, [7:2] zero
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [14:0] duty_first, [29:15] duty_second,
                                    // [44:30] duty_third, [45] manual_mode,
                                    // [48:46] manual_target, [50:49] fade_phase,
                                    // [62:51] rate_now, [63] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [15:0] period_load_reg;
    logic [15:0] long_press_reg;
    logic [6:0]  rate_step_reg;

    // controller state
    logic [7:0]  int0_reg, int1_reg, int2_reg;
    logic [7:0]  int0_next, int1_next, int2_next;
    logic [1:0]  phase_reg, phase_next;
    logic [11:0] rate_reg, rate_next;
    logic        mode_reg, mode_next;
    logic [2:0]  tgt_reg, tgt_next;
    logic [15:0] held_reg, held_next;
    logic [1:0]  short_reg, short_next;
    logic        long_reg, long_next;
    logic        open_reg, open_next;

    // pipeline valids
    logic        st_valid_reg;
    logic        prod_valid_reg;
    logic        out_valid_reg;

    // product stage
    logic [23:0] prod0_reg, prod1_reg, prod2_reg;
    logic        prod_mode_reg;
    logic [2:0]  prod_tgt_reg;
    logic [1:0]  prod_phase_reg;
    logic [11:0] prod_rate_reg;

    // output stage
    logic [14:0] duty0_reg, duty1_reg, duty2_reg;
    logic        out_mode_reg;
    logic [2:0]  out_tgt_reg;
    logic [1:0]  out_phase_reg;
    logic [11:0] out_rate_reg;

    // handshake and flow control
    logic        in_up, in_dn;
    logic        s_accept;
    logic        load_out, load_prod;
    logic        cfg_write;

    // auto fade datapath
    logic [12:0] rate_sum;
    logic [11:0] rate_after_up, rate_auto;
    logic [5:0]  rate_q, rate_ceil;
    logic        rate_rem_nz;
    logic [7:0]  src_lvl, dst_lvl, src_new, dst_new;
    logic [1:0]  dst_phase;
    logic        fade_wrap;
    logic        sel_hold;

    assign in_up = s_tdata[0];
    assign in_dn = s_tdata[1];

    // pipeline flow: each stage moves when the one after it is free or moving
    assign load_out  = prod_valid_reg && (!out_valid_reg || m_tready);
    assign load_prod = st_valid_reg && (!prod_valid_reg || load_out);
    assign s_tready  = !st_valid_reg || load_prod;
    assign s_accept  = s_tvalid && s_tready;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_PERIOD_LOAD: prdata = {16'd0, period_load_reg};
            REG_LONG_PRESS:  prdata = {16'd0, long_press_reg};
            REG_RATE_STEP:   prdata = {25'd0, rate_step_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_load_reg <= PERIOD_LOAD_RST;
            long_press_reg  <= LONG_PRESS_RST;
            rate_step_reg   <= RATE_STEP_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_PERIOD_LOAD: period_load_reg <= pwdata[15:0];
                REG_LONG_PRESS:  long_press_reg  <= pwdata[15:0];
                REG_RATE_STEP:   rate_step_reg   <= pwdata[6:0];
                default:         ;
            endcase
        end
    end

    // rate adjust with clamp, used in automatic mode
    assign rate_sum      = {1'b0, rate_reg} + {6'd0, rate_step_reg};
    assign rate_after_up = !in_up ? rate_reg :
                           (rate_sum > {1'b0, RATE_MAX}) ? RATE_MAX : rate_sum[11:0];
    always_comb begin
        rate_auto = rate_after_up;
        if (in_dn) begin
            if ({1'b0, rate_after_up} < {1'b0, RATE_MIN} + {6'd0, rate_step_reg}) begin
                rate_auto = RATE_MIN;
            end else begin
                rate_auto = rate_after_up - {5'd0, rate_step_reg};
            end
        end
    end

    // whole steps moved: floor for the destination, ceiling for the source
    assign rate_q      = div100(rate_auto);
    assign rate_rem_nz = (12'(rate_q) * 12'd100) != rate_auto;
    assign rate_ceil   = rate_q + {5'd0, rate_rem_nz};

    // source and destination channel of the current phase
    always_comb begin
        case (phase_reg)
            PH_0: begin
                src_lvl   = int0_reg;
                dst_lvl   = int1_reg;
                dst_phase = PH_1;
            end
            PH_1: begin
                src_lvl   = int1_reg;
                dst_lvl   = int2_reg;
                dst_phase = PH_2;
            end
            PH_2: begin
                src_lvl   = int2_reg;
                dst_lvl   = int0_reg;
                dst_phase = PH_0;
            end
            default: begin
                src_lvl   = int0_reg;
                dst_lvl   = int1_reg;
                dst_phase = PH_0;
            end
        endcase
    end

    assign fade_wrap = (16'(src_lvl) * HUND < SRC_FLOOR_HUND + 16'(rate_auto))
                    || (16'(dst_lvl) * HUND + 16'(rate_auto) >= DST_CEIL_HUND);
    assign src_new   = fade_wrap ? LVL_MIN : src_lvl - {2'd0, rate_ceil};
    assign dst_new   = fade_wrap ? LVL_MAX : dst_lvl + {2'd0, rate_q};

    // next state for one tick
    always_comb begin
        int0_next  = int0_reg;
        int1_next  = int1_reg;
        int2_next  = int2_reg;
        phase_next = phase_reg;
        rate_next  = rate_reg;
        mode_next  = mode_reg;
        tgt_next   = tgt_reg;
        held_next  = held_reg;
        short_next = short_reg;
        long_next  = long_reg;
        open_next  = open_reg;
        sel_hold   = 1'b0;

        // both buttons enter selection unless one is already running
        if (in_up && in_dn && !(mode_reg && tgt_reg == TGT_SELECT)) begin
            mode_next  = 1'b1;
            tgt_next   = TGT_SELECT;
            held_next  = 16'd0;
            short_next = 2'd0;
            long_next  = 1'b0;
            open_next  = 1'b0;
        end

        if (!mode_next) begin
            // automatic fade
            rate_next = rate_auto;
            if (fade_wrap) begin
                phase_next = dst_phase;
            end
            case (phase_reg)
                PH_0: begin
                    int0_next = src_new;
                    int1_next = dst_new;
                end
                PH_1: begin
                    int1_next = src_new;
                    int2_next = dst_new;
                end
                PH_2: begin
                    int2_next = src_new;
                    int0_next = dst_new;
                end
                default: ;
            endcase
        end else if (tgt_next == TGT_SELECT) begin
            // press counting while down is held
            if (open_next) begin
                if (in_up) begin
                    held_next = sat_inc(held_next);
                    sel_hold  = 1'b1;
                end else begin
                    if (held_next > long_press_reg) begin
                        long_next = 1'b1;
                    end else if (short_next != SHORT_MAX) begin
                        short_next = short_next + 2'd1;
                    end
                    open_next = 1'b0;
                end
            end
            if (!sel_hold) begin
                if (in_dn) begin
                    if (in_up) begin
                        open_next = 1'b1;
                        held_next = sat_inc(held_next);
                    end
                end else begin
                    if (long_next) begin
                        tgt_next = TGT_CH2;
                    end else if (short_next == 2'd1) begin
                        tgt_next = TGT_CH0;
                    end else if (short_next >= 2'd2) begin
                        tgt_next = TGT_CH1;
                    end
                    held_next  = 16'd0;
                    short_next = 2'd0;
                    long_next  = 1'b0;
                    open_next  = 1'b0;
                end
            end
        end else begin
            // manual step of the chosen channel
            case (tgt_next)
                TGT_CH0: int0_next = adj_level(int0_reg, in_up, in_dn);
                TGT_CH1: int1_next = adj_level(int1_reg, in_up, in_dn);
                TGT_CH2: int2_next = adj_level(int2_reg, in_up, in_dn);
                default: ;
            endcase
        end
    end

    // state registers and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int0_reg       <= LVL_MAX;
            int1_reg       <= LVL_MIN;
            int2_reg       <= LVL_MIN;
            phase_reg      <= PH_0;
            rate_reg       <= RATE_MIN;
            mode_reg       <= 1'b0;
            tgt_reg        <= TGT_NONE;
            held_reg       <= 16'd0;
            short_reg      <= 2'd0;
            long_reg       <= 1'b0;
            open_reg       <= 1'b0;
            st_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                int0_reg  <= int0_next;
                int1_reg  <= int1_next;
                int2_reg  <= int2_next;
                phase_reg <= phase_next;
                rate_reg  <= rate_next;
                mode_reg  <= mode_next;
                tgt_reg   <= tgt_next;
                held_reg  <= held_next;
                short_reg <= short_next;
                long_reg  <= long_next;
                open_reg  <= open_next;
            end
            if (s_tready) begin
                st_valid_reg <= s_tvalid;
            end
            if (!prod_valid_reg || load_out) begin
                prod_valid_reg <= load_prod;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= load_out;
            end
        end
    end

    // scaling pipeline: multiply, then divide by 1000
    always_ff @(posedge aclk) begin
        if (load_prod) begin
            prod0_reg      <= 24'(int0_reg) * 24'(period_load_reg);
            prod1_reg      <= 24'(int1_reg) * 24'(period_load_reg);
            prod2_reg      <= 24'(int2_reg) * 24'(period_load_reg);
            prod_mode_reg  <= mode_reg;
            prod_tgt_reg   <= tgt_reg;
            prod_phase_reg <= phase_reg;
            prod_rate_reg  <= rate_reg;
        end
        if (load_out) begin
            duty0_reg     <= div1000(prod0_reg);
            duty1_reg     <= div1000(prod1_reg);
            duty2_reg     <= div1000(prod2_reg);
            out_mode_reg  <= prod_mode_reg;
            out_tgt_reg   <= prod_tgt_reg;
            out_phase_reg <= prod_phase_reg;
            out_rate_reg  <= prod_rate_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rate_reg, out_phase_reg, out_tgt_reg, out_mode_reg,
                       duty2_reg, duty1_reg, duty0_reg};

    // rate stays inside its clamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rate_reg >= RATE_MIN) && (rate_reg <= RATE_MAX))
        else $error("fade rate left its range");

    // every intensity stays inside the level bounds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (int0_reg >= LVL_MIN) && (int0_reg <= LVL_MAX) &&
        (int1_reg >= LVL_MIN) && (int1_reg <= LVL_MAX) &&
        (int2_reg >= LVL_MIN) && (int2_reg <= LVL_MAX))
        else $error("intensity out of bounds");

    // automatic mode never carries a manual target
    assert property (@(posedge aclk) disable iff (!aresetn)
        !mode_reg |-> (tgt_reg == TGT_NONE))
        else $error("target set in automatic mode");

    // a tick that has updated state is not dropped before the product stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && !load_prod) |=> st_valid_reg)
        else $error("pending tick lost");

endmodule

/* tb/led_fade_checker.sv */
// checker for the fade controller: predicts every result frame and compares it on the output
module led_fade_checker
    import rgbfade_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] up_pressed, [1] down_pressed, [7:2] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // [14:0] duty_first, [29:15] duty_second,
                                    // [44:30] duty_third, [45] manual_mode,
                                    // [48:46] manual_target, [50:49] fade_phase,
                                    // [62:51] rate_now, [63] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          frames_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [14:0] duty0;
        logic [14:0] duty1;
        logic [14:0] duty2;
        logic        manual;
        logic [2:0]  target;
        logic [1:0]  phase;
        logic [11:0] rate;
    } led_frame_t;

    // register copies
    logic [15:0] cfg_load;
    logic [15:0] cfg_long;
    logic [6:0]  cfg_step;

    // controller state as predicted
    logic [7:0]  lvl [3];
    logic [1:0]  ph;
    logic [11:0] rate;
    logic        manual;
    logic [2:0]  tgt;
    logic [15:0] held;
    logic [1:0]  shorts;
    logic        long_seen;
    logic        press_open;

    led_frame_t  frames_due[$];

    initial begin
        fail_count     = 0;
        frames_waiting = 0;
    end

    task automatic clear_presses();
        held       = 16'd0;
        shorts     = 2'd0;
        long_seen  = 1'b0;
        press_open = 1'b0;
    endtask

    // automatic mode: rate update, then move intensity from source to destination
    task automatic fade_step(input logic up, input logic dn);
        int src, dst, r, step, s, d;
        src  = int'(ph);
        dst  = (ph == PH_2) ? 0 : src + 1;
        step = int'(cfg_step);
        r    = int'(rate);
        if (up) begin
            r = (r + step > int'(RATE_MAX)) ? int'(RATE_MAX) : r + step;
        end
        if (dn) begin
            r = (r < int'(RATE_MIN) + step) ? int'(RATE_MIN) : r - step;
        end
        rate = 12'(r);
        s = int'(lvl[src]) * 100 - r;
        d = int'(lvl[dst]) * 100 + r;
        if (s < int'(LVL_MIN) * 100 || d >= (int'(LVL_MAX) + 1) * 100) begin
            lvl[src] = LVL_MIN;
            lvl[dst] = LVL_MAX;
            ph       = 2'(dst);
        end else begin
            lvl[src] = 8'(s / 100);
            lvl[dst] = 8'(d / 100);
        end
    endtask

    // selection: count up presses while down is held, pick the channel on down release
    task automatic select_step(input logic up, input logic dn);
        logic still_held;
        still_held = 1'b0;
        if (press_open) begin
            if (up) begin
                if (held != 16'hFFFF) held = held + 16'd1;
                still_held = 1'b1;
            end else begin
                if (held > cfg_long) long_seen = 1'b1;
                else if (shorts != SHORT_MAX) shorts = shorts + 2'd1;
                press_open = 1'b0;
            end
        end
        if (!still_held) begin
            if (dn) begin
                if (up) begin
                    press_open = 1'b1;
                    if (held != 16'hFFFF) held = held + 16'd1;
                end
            end else begin
                if (long_seen) tgt = TGT_CH2;
                else if (shorts == 2'd1) tgt = TGT_CH0;
                else if (shorts >= 2'd2) tgt = TGT_CH1;
                clear_presses();
            end
        end
    endtask

    // manual adjust of the selected channel, saturating at the bounds
    task automatic adjust_step(input logic up, input logic dn);
        int ch;
        ch = int'(tgt) - 1;
        if (ch >= 0 && ch <= 2) begin
            if (up) lvl[ch] = (lvl[ch] >= LVL_MAX) ? LVL_MAX : lvl[ch] + 8'd1;
            if (dn) lvl[ch] = (lvl[ch] <= LVL_MIN) ? LVL_MIN : lvl[ch] - 8'd1;
        end
    endtask

    task automatic advance_tick(input logic up, input logic dn);
        if (up && dn && !(manual && tgt == TGT_SELECT)) begin
            manual = 1'b1;
            tgt    = TGT_SELECT;
            clear_presses();
        end
        if (!manual) fade_step(up, dn);
        else if (tgt == TGT_SELECT) select_step(up, dn);
        else adjust_step(up, dn);
    endtask

    function automatic logic [14:0] duty_of(input logic [7:0] level);
        return 15'((32'(level) * 32'(cfg_load)) / 32'd1000);
    endfunction

    function automatic led_frame_t frame_now();
        led_frame_t f;
        f.duty0  = duty_of(lvl[0]);
        f.duty1  = duty_of(lvl[1]);
        f.duty2  = duty_of(lvl[2]);
        f.manual = manual;
        f.target = tgt;
        f.phase  = ph;
        f.rate   = rate;
        return f;
    endfunction

    task automatic compare_field(input string label, input int want, input int seen);
        if (want != seen) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, label, want, seen);
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin : watch
        led_frame_t want;
        if (!aresetn) begin
            cfg_load = PERIOD_LOAD_RST;
            cfg_long = LONG_PRESS_RST;
            cfg_step = RATE_STEP_RST;
            lvl[0]   = LVL_MAX;
            lvl[1]   = LVL_MIN;
            lvl[2]   = LVL_MIN;
            ph       = PH_0;
            rate     = RATE_MIN;
            manual   = 1'b0;
            tgt      = TGT_NONE;
            clear_presses();
            frames_due.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PERIOD_LOAD: cfg_load = pwdata[15:0];
                    REG_LONG_PRESS:  cfg_long = pwdata[15:0];
                    REG_RATE_STEP:   cfg_step = pwdata[6:0];
                    default: ;
                endcase
            end
            // result transaction
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with no frame expected, expected none actual %h",
                             $time, m_tdata);
                end else begin
                    want = frames_due.pop_front();
                    compare_field("duty_first",    want.duty0,  m_tdata[14:0]);
                    compare_field("duty_second",   want.duty1,  m_tdata[29:15]);
                    compare_field("duty_third",    want.duty2,  m_tdata[44:30]);
                    compare_field("manual_mode",   want.manual, m_tdata[45]);
                    compare_field("manual_target", want.target, m_tdata[48:46]);
                    compare_field("fade_phase",    want.phase,  m_tdata[50:49]);
                    compare_field("rate_now",      want.rate,   m_tdata[62:51]);
                end
            end
            // tick transaction
            if (s_tvalid && s_tready) begin
                advance_tick(s_tdata[0], s_tdata[1]);
                frames_due.push_back(frame_now());
            end
        end
        frames_waiting <= frames_due.size();
    end

endmodule

/* tb/tb.sv */
// testbench top: drives button ticks and register writes into the fade controller
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbfade_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TICK_TARGET    = 600;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;    // [0] up_pressed, [1] down_pressed, [7:2] zero
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [63:0] m_tdata;            // [14:0] duty_first, [29:15] duty_second,
                                     // [44:30] duty_third, [45] manual_mode,
                                     // [48:46] manual_target, [50:49] fade_phase,
                                     // [62:51] rate_now, [63] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int frames_waiting;
    int ticks_sent  = 0;
    int reg_writes  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    always #5 aclk = ~aclk;

    rgb_led_fade_cycle_controller_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    led_fade_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .frames_waiting (frames_waiting)
    );

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) m_tready <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one tick transaction, then maybe a gap
    task automatic send_tick(input logic up, input logic dn);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, dn, up};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // mostly the given buttons, now and then a random pair
    task automatic send_mostly(input logic up, input logic dn);
        if ($urandom_range(0, 15) == 0) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            send_tick(up, dn);
        end
    endtask

    // hold off until every expected frame has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_waiting != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic configure(input int load, input int long_ticks, input int step);
        drain();
        write_reg(REG_PERIOD_LOAD, load);
        write_reg(REG_LONG_PRESS, long_ticks);
        write_reg(REG_RATE_STEP, step);
    endtask

    // automatic fading with random up and down, never both
    task automatic run_auto(input int n, input int up_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < up_pct) send_tick(1'b1, 1'b0);
            else if (r < up_pct + (100 - up_pct) / 2) send_tick(1'b0, 1'b1);
            else send_tick(1'b0, 1'b0);
        end
    endtask

    // both buttons to enter, a few up presses under down, then release
    task automatic run_selection();
        int presses;
        send_tick(1'b1, 1'b1);
        repeat ($urandom_range(0, 12)) send_mostly(1'b1, 1'b1);
        presses = $urandom_range(0, 3);
        repeat (presses) begin
            repeat ($urandom_range(1, 3)) send_mostly(1'b0, 1'b1);
            send_tick(1'b1, 1'b1);
            repeat ($urandom_range(0, 12)) send_mostly(1'b1, 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(0, 2)) send_mostly(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // stepping of the selected channel, mostly in one direction
    task automatic run_adjust();
        logic dir;
        int   r;
        dir = 1'($urandom_range(0, 1));
        repeat ($urandom_range(3, 40)) begin
            r = $urandom_range(0, 9);
            if (r < 7) send_mostly(dir, !dir);
            else if (r < 9) send_mostly(!dir, dir);
            else send_mostly(1'b0, 1'b0);
        end
    endtask

    initial begin
        int seg_load [5];
        int seg_long [5];
        int seg_step [5];
        int seg_up   [5];
        int round_long [3];
        int stop_at;

        seg_load = '{0, 65535, -1, 11362, -1};
        seg_long = '{65535, 1, -1, 170, -1};
        seg_step = '{1, 127, -1, 100, 64};
        seg_up   = '{50, 80, 45, 85, 25};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: idle ticks, rate up, rate down into the floor
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
        repeat (5) send_tick(1'b0, 1'b1);

        // oversized rate step and full-scale load
        configure(65535, 1, 127);
        repeat (3) send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b1);

        // random fading across several register settings
        for (int i = 0; i < 5; i++) begin
            configure(seg_load[i] < 0 ? $urandom_range(0, 65535) : seg_load[i],
                      seg_long[i] < 0 ? $urandom_range(1, 65535) : seg_long[i],
                      seg_step[i] < 0 ? $urandom_range(1, 127) : seg_step[i]);
            run_auto(60, seg_up[i]);
        end

        // enter manual: one short press selects channel 0, then step it
        configure($urandom_range(0, 65535), 4, $urandom_range(1, 127));
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // random selections and adjustments, the last round without idling
        round_long = '{$urandom_range(2, 30), 65535, 1};
        for (int rnd = 0; rnd < 3; rnd++) begin
            configure($urandom_range(0, 65535), round_long[rnd], $urandom_range(1, 127));
            if (rnd == 2) quiet = 1'b1;
            stop_at = (rnd == 2) ? TICK_TARGET : ticks_sent + (TICK_TARGET - ticks_sent) / 3;
            while (ticks_sent < stop_at) begin
                run_selection();
                run_adjust();
            end
        end

        drain();
        repeat (10) @(posedge aclk);

        $display("covered %0d ticks: fading under %0d register writes, then manual selection",
                 ticks_sent, reg_writes);
        $display("and channel stepping with short and long presses and random back-pressure");
        if (fail_count == 0 && frames_waiting == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
